FILE: hdl/hamming_nearest_match_ratio_test_defines.svh
// assertion macros for the hamming nearest match block
`ifndef HAMMING_NEAREST_MATCH_RATIO_TEST_DEFINES_SVH
`define HAMMING_NEAREST_MATCH_RATIO_TEST_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define HNMRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define HNMRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hnmrt_pkg.sv
// types and constants for the hamming nearest match block
package hnmrt_pkg;

  localparam int unsigned WORD_W       = 64;
  localparam int unsigned IN_DESC_BITS = 4 * WORD_W;
  localparam int unsigned LANE_PC_W    = 7;
  localparam int unsigned CFG_W        = 9;
  localparam int unsigned REG_IDX_W    = 1;
  localparam int unsigned DIST_OUT_W   = 9;
  localparam int unsigned FRAME_OUT_W  = 11;
  localparam int unsigned ECHO_W       = 12;

  localparam logic [REG_IDX_W-1:0] REG_DIST_THRESHOLD = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_RATIO_Q8       = 1'b1;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 9'd50;
  localparam logic [CFG_W-1:0] RATIO_RESET     = 9'd204;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [WORD_W-1:0] desc_word0;
    logic [WORD_W-1:0] desc_word1;
    logic [WORD_W-1:0] desc_word2;
    logic [WORD_W-1:0] desc_word3;
    logic              landmark_valid;
    logic [ECHO_W-1:0] query_index;
  } in_item_t;

  typedef struct packed {
    logic                   match_found;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic [ECHO_W-1:0]      echo_index;
    logic [DIST_OUT_W-1:0]  best_distance;
    logic [DIST_OUT_W-1:0]  second_distance;
    logic                   store_full;
  } out_item_t;

endpackage

FILE: hdl/hamming_nearest_match_ratio_test.sv
// brute-force hamming nearest match with threshold and q8 ratio test
//
//  channel  | signals                             | direction
//  ---------+-------------------------------------+----------
//  in       | in_valid_i, in_ready_o, in_item_i   | sink
//  out      | out_valid_o, out_ready_i, out_item_o| source
//  cfg      | cfg_we_i, cfg_index_i, cfg_data_i   | sink, write only
//
// a query with landmark scans the store: one stored descriptor is read per cycle from the
// store memory, then the popcount and running-minimum stages drain, the decision is
// staged and the result moves to the output register once that register is free
// clear, load, ignored command and query without landmark are staged at their transaction
// and move to the output register once it is free; the next transaction is taken after that
// reset needs no clearing pass: matched flags are only read below the fill
// count, and every entry there was written by a load since the last clear
// a stalled output holds the finished result; the next transaction is taken while it
// waits, its result waits in the staging register, and nothing more is taken until the
// output register frees
`include "hamming_nearest_match_ratio_test_defines.svh"

module hamming_nearest_match_ratio_test
  import hnmrt_pkg::*;
#(
  parameter int unsigned FRAME_CAPACITY = 2048,
  parameter int unsigned DESC_BITS      = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // derived sizes
  localparam int unsigned DESC_WORDS = (DESC_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned LANE_BITS  = DESC_WORDS * WORD_W;
  localparam int unsigned CP_BITS    = (DESC_BITS < IN_DESC_BITS) ? DESC_BITS : IN_DESC_BITS;
  localparam int unsigned DIST_W     = $clog2(DESC_BITS + 1);
  localparam int unsigned CNT_W      = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned IDX_W      = $clog2(FRAME_CAPACITY);
  localparam int unsigned PROD_W     = CFG_W + DIST_W;
  localparam int unsigned FI_CP      = (IDX_W < FRAME_OUT_W) ? IDX_W : FRAME_OUT_W;
  localparam int unsigned DO_CP      = (DIST_W < DIST_OUT_W) ? DIST_W : DIST_OUT_W;

  // swar population count of one 64-bit lane
  function automatic logic [LANE_PC_W-1:0] popcount64(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    a = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    c = c + (c >> 8);
    c = c + (c >> 16);
    c = c + (c >> 32);
    return c[LANE_PC_W-1:0];
  endfunction

  // sequencer
  state_e state_q, state_d;

  // configuration registers
  logic [CFG_W-1:0] thr_q;
  logic [CFG_W-1:0] ratio_q;

  // store bookkeeping
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] rd_idx_q;

  // query under work
  logic [DESC_BITS-1:0] q_vec_q;
  logic [ECHO_W-1:0]    echo_q;

  // storage: descriptors and matched flags
  logic [DESC_BITS-1:0] desc_mem [FRAME_CAPACITY];
  logic                 flag_mem [FRAME_CAPACITY];

  // stage 1: memory read
  logic                 p1_valid_q;
  logic [IDX_W-1:0]     p1_idx_q;
  logic [DESC_BITS-1:0] mem_rd_q;
  logic                 flag_rd_q;

  // stage 2: per-lane popcount
  logic                 p2_valid_q;
  logic                 p2_skip_q;
  logic [IDX_W-1:0]     p2_idx_q;
  logic [LANE_PC_W-1:0] pc_q [DESC_WORDS];

  // stage 3: running best and second best
  logic [DIST_W-1:0] best_q;
  logic [DIST_W-1:0] second_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              have_q;

  // result staging and output register
  out_item_t res_q;
  out_item_t out_q;
  logic      out_valid_q;

  // control
  logic                 in_acc;
  logic                 is_query;
  logic                 issue;
  logic                 res_fire;
  logic                 decide;
  logic                 match_ok;
  logic                 store_has_room;
  logic                 desc_we;
  logic                 flag_we;
  logic [IDX_W-1:0]     flag_wa;
  logic                 flag_wd;
  logic [IN_DESC_BITS-1:0] in_desc;
  logic [DESC_BITS-1:0] in_vec;
  logic [LANE_BITS-1:0] diff;
  logic [DIST_W-1:0]    dist_sum;
  logic [PROD_W-1:0]    ratio_prod;
  logic [PROD_W-1:0]    best_scaled;
  logic [FRAME_OUT_W-1:0] fidx;
  logic [DIST_OUT_W-1:0]  best_out;
  logic [DIST_OUT_W-1:0]  second_out;
  logic [DIST_OUT_W-1:0]  none_dist;

  // incoming descriptor, trimmed or zero-padded to DESC_BITS
  assign in_desc = {in_item_i.desc_word3, in_item_i.desc_word2,
                    in_item_i.desc_word1, in_item_i.desc_word0};

  always_comb begin
    in_vec = '0;
    in_vec[CP_BITS-1:0] = in_desc[CP_BITS-1:0];
  end

  assign in_acc         = in_valid_i && in_ready_o;
  assign is_query       = (in_item_i.command == CMD_QUERY) && in_item_i.landmark_valid;
  assign store_has_room = count_q < CNT_W'(FRAME_CAPACITY);
  assign desc_we        = in_acc && (in_item_i.command == CMD_LOAD) && store_has_room;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = is_query ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (rd_idx_q >= count_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_valid_q && !p2_valid_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    decide     = 1'b0;
    res_fire   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SCAN:   issue      = rd_idx_q < count_q;
      ST_DRAIN:  ;
      ST_DECIDE: decide     = 1'b1;
      ST_RESULT: res_fire   = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RESET;
      ratio_q <= RATIO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DIST_THRESHOLD: thr_q   <= cfg_data_i;
        REG_RATIO_Q8:       ratio_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // descriptor store: one write port for loads, one registered read for the scan
  always_ff @(posedge clk_i) begin
    if (desc_we) begin
      desc_mem[count_q[IDX_W-1:0]] <= in_vec;
    end
    if (issue) begin
      mem_rd_q <= desc_mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  // matched flags: cleared by the load that fills an entry, set by a match
  assign flag_we = desc_we || (decide && match_ok);
  assign flag_wa = decide ? best_idx_q : count_q[IDX_W-1:0];
  assign flag_wd = decide;

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    if (issue) begin
      flag_rd_q <= flag_mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  // fill count and scan address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
    end else begin
      if (in_acc && (in_item_i.command == CMD_CLEAR)) begin
        count_q <= '0;
      end else if (desc_we) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (in_acc) begin
        rd_idx_q <= '0;
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
    end
  end

  // query capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      q_vec_q <= in_vec;
      echo_q  <= in_item_i.query_index;
    end
  end

  // distance pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= issue;
      p2_valid_q <= p1_valid_q;
    end
  end

  // lane-wise xor, zero-padded to whole lanes
  always_comb begin
    diff = '0;
    diff[DESC_BITS-1:0] = q_vec_q ^ mem_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_idx_q <= rd_idx_q[IDX_W-1:0];
    end
    p2_skip_q <= flag_rd_q;
    p2_idx_q  <= p1_idx_q;
    for (int l = 0; l < DESC_WORDS; l++) begin
      pc_q[l] <= popcount64(diff[l*WORD_W +: WORD_W]);
    end
  end

  // lane sum
  always_comb begin
    dist_sum = '0;
    for (int l = 0; l < DESC_WORDS; l++) begin
      dist_sum = dist_sum + DIST_W'(pc_q[l]);
    end
  end

  // best / second-best tracking, first strictly smaller distance wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (in_acc) begin
      have_q <= 1'b0;
    end else if (p2_valid_q && !p2_skip_q && (dist_sum < best_q)) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      best_q     <= DIST_W'(DESC_BITS);
      second_q   <= DIST_W'(DESC_BITS);
      best_idx_q <= '0;
    end else if (p2_valid_q && !p2_skip_q) begin
      if (dist_sum < best_q) begin
        second_q   <= best_q;
        best_q     <= dist_sum;
        best_idx_q <= p2_idx_q;
      end else if (dist_sum < second_q) begin
        second_q <= dist_sum;
      end
    end
  end

  // threshold and q8 ratio test: ratio * second >= best * 256
  assign ratio_prod  = PROD_W'(ratio_q) * PROD_W'(second_q);
  assign best_scaled = PROD_W'(best_q) << 8;
  assign match_ok    = have_q && (PROD_W'(best_q) <= PROD_W'(thr_q))
                       && (ratio_prod >= best_scaled);

  // output field formatting, masked to the port widths
  always_comb begin
    fidx       = '0;
    best_out   = '0;
    second_out = '0;
    fidx[FI_CP-1:0]       = best_idx_q[FI_CP-1:0];
    best_out[DO_CP-1:0]   = best_q[DO_CP-1:0];
    second_out[DO_CP-1:0] = second_q[DO_CP-1:0];
  end

  assign none_dist = DIST_OUT_W'(DESC_BITS);

  // result staging
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q.match_found     <= 1'b0;
      res_q.frame_index     <= '0;
      res_q.echo_index      <= in_item_i.query_index;
      res_q.best_distance   <= none_dist;
      res_q.second_distance <= none_dist;
      res_q.store_full      <= (in_item_i.command == CMD_LOAD) && !store_has_room;
    end else if (decide) begin
      res_q.match_found     <= match_ok;
      res_q.frame_index     <= match_ok ? fidx : '0;
      res_q.echo_index      <= echo_q;
      res_q.best_distance   <= best_out;
      res_q.second_distance <= second_out;
      res_q.store_full      <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `HNMRT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(FRAME_CAPACITY),
                    "fill count above capacity")
  `HNMRT_ASSERT_NOW(a_best_le_second, state_q == ST_DECIDE, best_q <= second_q,
                    "best distance above second best at decision")
  `HNMRT_ASSERT_NOW(a_drained, state_q == ST_DECIDE, !p1_valid_q && !p2_valid_q,
                    "decision taken with distances still in flight")
  `HNMRT_ASSERT_NOW(a_no_match_index, out_valid_q && !out_q.match_found,
                    out_q.frame_index == '0, "frame index set without a match")
  `HNMRT_ASSERT_NEXT(a_match_staged, decide && match_ok,
                     state_q == ST_RESULT && res_q.match_found,
                     "accepted match not staged as result")

endmodule

FILE: verif/hamming_nearest_match_ratio_test_test.sv
// testbench for the hamming nearest match block: predictor, scoreboard and random traffic
`timescale 1ns / 1ps

// expected-result store with its own copy of the descriptor store and match flags
class nearest_match_board;
  localparam int unsigned CAP = 2048;

  bit [255:0]  frame_desc [CAP];
  bit          taken [CAP];
  int unsigned fill;
  int unsigned thr;
  int unsigned ratio;

  hnmrt_pkg::out_item_t pending_results [$];

  int unsigned mismatch_cnt;
  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned match_cnt;
  int unsigned reject_cnt;
  int unsigned dropped_cnt;

  function new();
    fill = 0;
    thr = 50;
    ratio = 204;
    foreach (taken[i]) taken[i] = 1'b0;
  endfunction

  function void set_regs(int unsigned new_thr, int unsigned new_ratio);
    thr = new_thr;
    ratio = new_ratio;
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  // nearest-match prediction for one accepted transaction
  function void take_request(hnmrt_pkg::in_item_t it);
    hnmrt_pkg::out_item_t res;
    bit [255:0]  probe;
    int unsigned best;
    int unsigned second;
    int unsigned best_at;
    int unsigned hd;
    bit          seen;
    accepted_cnt++;
    res = '0;
    res.echo_index = it.query_index;
    best = 256;
    second = 256;
    best_at = 0;
    seen = 1'b0;
    probe = {it.desc_word3, it.desc_word2, it.desc_word1, it.desc_word0};
    case (it.command)
      hnmrt_pkg::CMD_CLEAR: begin
        fill = 0;
        foreach (taken[i]) taken[i] = 1'b0;
      end
      hnmrt_pkg::CMD_LOAD: begin
        if (fill >= CAP) begin
          res.store_full = 1'b1;
          dropped_cnt++;
        end else begin
          frame_desc[fill] = probe;
          taken[fill] = 1'b0;
          fill++;
        end
      end
      hnmrt_pkg::CMD_QUERY: begin
        if (it.landmark_valid) begin
          for (int i = 0; i < fill; i++) begin
            if (!taken[i]) begin
              hd = $countones(probe ^ frame_desc[i]);
              if (hd < best) begin
                second = best;
                best = hd;
                best_at = i;
                seen = 1'b1;
              end else if (hd < second) begin
                second = hd;
              end
            end
          end
          if (seen && best <= thr && ratio * second >= best * 256) begin
            res.match_found = 1'b1;
            res.frame_index = 11'(best_at);
            taken[best_at] = 1'b1;
            match_cnt++;
          end else if (seen) begin
            reject_cnt++;
          end
        end
      end
      default: ;
    endcase
    res.best_distance = 9'(best);
    res.second_distance = 9'(second);
    pending_results.push_back(res);
  endfunction

  function void check_result(hnmrt_pkg::out_item_t got);
    hnmrt_pkg::out_item_t exp;
    checked_cnt++;
    if (pending_results.size() == 0) begin
      if (mismatch_cnt < 10)
        $display("error: unexpected result %p", got);
      mismatch_cnt++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.match_found !== exp.match_found || got.frame_index !== exp.frame_index ||
        got.echo_index !== exp.echo_index || got.best_distance !== exp.best_distance ||
        got.second_distance !== exp.second_distance || got.store_full !== exp.store_full)
    begin
      if (mismatch_cnt < 10) begin
        $display("error: result %0d mismatch", checked_cnt);
        $display("  expected found=%0d frame=%0d echo=%0d best=%0d second=%0d full=%0d",
                 exp.match_found, exp.frame_index, exp.echo_index, exp.best_distance,
                 exp.second_distance, exp.store_full);
        $display("  actual   found=%0d frame=%0d echo=%0d best=%0d second=%0d full=%0d",
                 got.match_found, got.frame_index, got.echo_index, got.best_distance,
                 got.second_distance, got.store_full);
      end
      mismatch_cnt++;
    end
  endfunction
endclass

module hamming_nearest_match_ratio_test_test;
  import hnmrt_pkg::*;

  // command 3 has no name in the package; the block ignores it
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_DIST_THRESHOLD;
  logic [CFG_W-1:0]     cfg_data = '0;

  // when set, neither side inserts bubbles
  bit steady = 1'b0;
  int unsigned cfg_writes = 0;

  // host-side copy of what is loaded, only used to aim queries near stored entries
  logic [255:0] stored_copy [$];

  nearest_match_board board = new;

  hamming_nearest_match_ratio_test u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side backpressure: out_ready drops at random with probability 16/100, never while steady
  always @(posedge clk_i) begin
    out_ready <= steady || ($urandom_range(99) >= 16);
  end

  // monitor: sampled at the edge, before any nonblocking update lands
  // a result never belongs to a transaction accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) board.check_result(out_item_o);
      if (in_valid && in_ready_o) board.take_request(in_item);
    end
  end

  // generous cap on the whole run
  initial begin
    #2000000;
    $display("timeout with %0d results still expected", board.pending());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic in_item_t pack_item(logic [1:0] cmd, logic [255:0] d, logic lm,
                                         logic [11:0] qi);
    in_item_t it;
    it.command = cmd;
    it.desc_word0 = d[63:0];
    it.desc_word1 = d[127:64];
    it.desc_word2 = d[191:128];
    it.desc_word3 = d[255:192];
    it.landmark_valid = lm;
    it.query_index = qi;
    return it;
  endfunction

  // mostly dense random descriptors, sometimes all-zero, all-one or sparse
  function automatic logic [255:0] rand_desc();
    logic [255:0] d;
    int unsigned mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 8; i++) d[i*32 +: 32] = $urandom();
    if (mode == 0) d = '0;
    else if (mode == 1) d = '1;
    else if (mode == 2) begin
      for (int i = 0; i < 8; i++) d[i*32 +: 32] = d[i*32 +: 32] & $urandom() & $urandom();
    end
    return d;
  endfunction

  function automatic logic [255:0] flip_bits(logic [255:0] d, int unsigned k);
    logic [7:0] b;
    for (int i = 0; i < k; i++) begin
      b = 8'($urandom_range(255));
      d[b] = ~d[b];
    end
    return d;
  endfunction

  // hold valid until the transaction is taken, with random bubbles before it
  task automatic push_item(input in_item_t it);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // wait until every expected result is back, with the input held idle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(int unsigned thr, int unsigned rat);
    cfg_we <= 1'b1;
    cfg_index <= REG_DIST_THRESHOLD;
    cfg_data <= CFG_W'(thr);
    @(posedge clk_i);
    cfg_index <= REG_RATIO_Q8;
    cfg_data <= CFG_W'(rat);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.set_regs(thr, rat);
    cfg_writes += 2;
  endtask

  // one random transaction: mostly loads and queries aimed near stored entries
  task automatic send_random();
    in_item_t     it;
    logic [255:0] d;
    int unsigned  roll;
    int unsigned  k;
    roll = $urandom_range(99);
    d = rand_desc();
    if (roll < 6 || (roll < 35 && stored_copy.size() >= 40)) begin
      it = pack_item(CMD_CLEAR, d, 1'($urandom()), 12'($urandom()));
      stored_copy.delete();
    end else if (roll < 35) begin
      it = pack_item(CMD_LOAD, d, 1'($urandom()), 12'($urandom()));
      stored_copy.push_back(d);
    end else if (roll < 88 && stored_copy.size() != 0) begin
      k = $urandom_range(9);
      if (k < 6) k = $urandom_range(6);
      else if (k < 8) k = $urandom_range(40, 7);
      else k = $urandom_range(128, 41);
      d = flip_bits(stored_copy[$urandom_range(stored_copy.size() - 1)], k);
      it = pack_item(CMD_QUERY, d, $urandom_range(9) != 0, 12'($urandom()));
    end else if (roll < 95) begin
      it = pack_item(CMD_QUERY, d, 1'($urandom()), 12'($urandom()));
    end else begin
      it = pack_item(CMD_SPARE, d, 1'($urandom()), 12'($urandom()));
    end
    push_item(it);
  endtask

  initial begin
    logic [255:0] pat;
    logic [255:0] alt;
    int unsigned  thr_set [6];
    int unsigned  rat_set [6];

    // reset held low at the start, never asserted again
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset register values (threshold 50, ratio 204)
    pat = rand_desc() | 256'h1;
    alt = rand_desc();
    push_item(pack_item(CMD_QUERY, '1, 1'b1, 12'd0));           // empty store
    push_item(pack_item(CMD_LOAD, '0, 1'b0, 12'd1));
    push_item(pack_item(CMD_QUERY, '1, 1'b1, 12'd2));           // only distance 256 seen
    push_item(pack_item(CMD_LOAD, '1, 1'b1, 12'd3));
    push_item(pack_item(CMD_QUERY, '1, 1'b0, 12'd4));           // no landmark
    push_item(pack_item(CMD_QUERY, '1, 1'b1, 12'd5));           // exact hit on entry 1
    push_item(pack_item(CMD_LOAD, pat, 1'b0, 12'd6));
    push_item(pack_item(CMD_LOAD, pat, 1'b0, 12'd7));
    push_item(pack_item(CMD_QUERY, pat, 1'b1, 12'd8));          // tie, lower index wins
    push_item(pack_item(CMD_QUERY, pat ^ {{196{1'b0}}, {60{1'b1}}}, 1'b1, 12'd9)); // over threshold
    push_item(pack_item(CMD_SPARE, alt, 1'b1, 12'd10));         // ignored command
    push_item(pack_item(CMD_CLEAR, alt, 1'b1, 12'd11));
    push_item(pack_item(CMD_LOAD, alt, 1'b1, 12'd12));
    push_item(pack_item(CMD_QUERY, alt, 1'b1, 12'd13));         // match
    push_item(pack_item(CMD_QUERY, alt, 1'b1, 12'd14));         // every entry already matched
    push_item(pack_item(CMD_LOAD, alt, 1'b0, 12'd15));
    push_item(pack_item(CMD_LOAD, alt ^ 256'h7ff, 1'b0, 12'd16));
    push_item(pack_item(CMD_QUERY, alt ^ 256'h1f, 1'b1, 12'd4095)); // best 5 vs 6, ratio fails
    push_item(pack_item(CMD_CLEAR, '0, 1'b0, 12'd4095));
    wait_quiet();

    // random phases over register extremes and two random settings
    thr_set = '{0, 256, 256, 0, $urandom_range(256), $urandom_range(256)};
    rat_set = '{0, 256, 0, 256, $urandom_range(256), $urandom_range(256)};
    for (int p = 0; p < 6; p++) begin
      write_regs(thr_set[p], rat_set[p]);
      steady = (p == 1);
      repeat (42) send_random();
      wait_quiet();
      steady = 1'b0;
    end

    // back to the reset settings for a last stretch
    write_regs(50, 204);
    repeat (20) send_random();
    wait_quiet();
    repeat (20) @(posedge clk_i);

    $display("covered %0d transactions in, %0d results checked, %0d register writes",
             board.accepted_cnt, board.checked_cnt, cfg_writes);
    $display("queries matched %0d, rejected %0d; loads dropped on a full store %0d",
             board.match_cnt, board.reject_cnt, board.dropped_cnt);
    if (board.mismatch_cnt == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", board.mismatch_cnt);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hnmrt_pkg.sv
hdl/hamming_nearest_match_ratio_test.sv
verif/hamming_nearest_match_ratio_test_test.sv
